### rtl/tpts_pkg.sv
package tpts_pkg;

  localparam int DEF_MAX_NODES   = 64;
  localparam int DEF_NUM_WORKERS = 3;

  localparam int NODE_W  = 7;
  localparam int DUR_W   = 16;
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 2;
  localparam int WID_W   = 2;
  localparam int CHUNK_W = 8;
  localparam logic [NODE_W-1:0] CNT_SAT = 7'd127;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_LOAD    = 2'd1,
    REQ_BEGIN   = 2'd2,
    REQ_ADVANCE = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    EV_FINISH = 2'd0,
    EV_START  = 2'd1,
    EV_DONE   = 2'd2,
    EV_STALL  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [WID_W-1:0]   wid;
    logic [NODE_W-1:0]  tsk;
    logic [TIME_W-1:0]  evt;
    logic [TIME_W-1:0]  fin;
  } result_t;

  // lowest set bit of one chunk: {found, position}
  function automatic logic [3:0] lowest8(input logic [CHUNK_W-1:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, 3'(i)};
      end
    end
    return r;
  endfunction

endpackage

### rtl/tree_precedence_task_scheduler.sv
// Tree precedence task scheduler. Requests arrive one at a time on the input
// channel and are worked through by a sequencer around two memories with
// registered reads: a node table (parent, duration) and a pending-child count
// table. Clear and reset run a clearing pass over the whole padded count
// table (8*ceil((MAX_NODES+1)/8) entries, 72 at the default size) during which
// no request is taken; the configuration register can be written at any time.
// A load with a valid index writes the node table and, for a valid parent,
// reads and then raises the parent's saturating count; a begin reads the count
// of each node in use and marks those with no pending children ready. An
// advance runs the retire check over every worker (a retiring worker reads its
// node, then its parent's count), the ready-set search for each idle worker
// (8 nodes a cycle), and the earliest-finish search unless the run is done,
// and waits whenever the output side stalls a result. Results leave through
// one output register backed by a one-deep holding register, so the final result of an advance carries last.
module tree_precedence_task_scheduler
  import tpts_pkg::*;
#(
  parameter int MAX_NODES   = tpts_pkg::DEF_MAX_NODES,
  parameter int NUM_WORKERS = tpts_pkg::DEF_NUM_WORKERS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tpts_pkg::NODE_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic [tpts_pkg::NODE_W-1:0] node_index,
  input  logic [tpts_pkg::NODE_W-1:0] node_parent,
  input  logic [tpts_pkg::DUR_W-1:0]  node_duration,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  event_kind,
  output logic [1:0]                  worker,
  output logic [tpts_pkg::NODE_W-1:0] task_res,
  output logic [tpts_pkg::TIME_W-1:0] event_time,
  output logic [tpts_pkg::TIME_W-1:0] finish_time,
  output logic                        last
);

  import tpts_pkg::*;

  // Node addressing: the ready set and both tables are padded to whole chunks.
  localparam int NCH = (MAX_NODES + 1 + CHUNK_W - 1) / CHUNK_W;
  localparam int RW  = NCH * CHUNK_W;
  localparam int AW  = $clog2(RW);
  localparam int CIW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int WW  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int CW  = AW + 1;
  localparam int NTW = NODE_W + DUR_W;

  typedef enum logic [13:0] {
    S_INIT     = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_LOAD     = 14'b00000000000100,
    S_BEG_RD   = 14'b00000000001000,
    S_BEG_CK   = 14'b00000000010000,
    S_RET_CHK  = 14'b00000000100000,
    S_RET_TBL  = 14'b00000001000000,
    S_RET_CNT  = 14'b00000010000000,
    S_DSP_CHK  = 14'b00000100000000,
    S_DSP_SCAN = 14'b00001000000000,
    S_DSP_TBL  = 14'b00010000000000,
    S_RPT      = 14'b00100000000000,
    S_JUMP     = 14'b01000000000000,
    S_FLUSH    = 14'b10000000000000
  } state_t;

  state_t state;

  // Configuration and run state
  logic [NODE_W-1:0] node_count;
  logic [RW-1:0]     ready;
  logic              busy [NUM_WORKERS];
  logic [AW-1:0]     wtask [NUM_WORKERS];
  logic [TIME_W-1:0] wfin [NUM_WORKERS];
  logic [TIME_W-1:0] now;
  logic [CW-1:0]     completed;

  // Sequencer working registers
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     par_r;
  logic [AW-1:0]     t_r;
  logic [WW-1:0]     w;
  logic [CIW-1:0]    chunk;
  logic              any_r;
  logic [TIME_W-1:0] best_r;

  // Result path: holding register in front of the output register
  result_t held;
  logic    held_valid;
  result_t out_r;
  logic    out_last;

  // Memory ports
  logic              pc_we, pc_re, nt_we, nt_re;
  logic [AW-1:0]     pc_waddr, pc_raddr, nt_waddr, nt_raddr;
  logic [NODE_W-1:0] pc_wdata, pc_rdata;
  logic [NTW-1:0]    nt_wdata, nt_rdata;

  tpts_ram #(.WIDTH(NODE_W), .DEPTH(RW)) u_count_ram (
    .clk   (clk),
    .we    (pc_we),
    .waddr (pc_waddr),
    .wdata (pc_wdata),
    .re    (pc_re),
    .raddr (pc_raddr),
    .rdata (pc_rdata)
  );

  tpts_ram #(.WIDTH(NTW), .DEPTH(RW)) u_node_ram (
    .clk   (clk),
    .we    (nt_we),
    .waddr (nt_waddr),
    .wdata (nt_wdata),
    .re    (nt_re),
    .raddr (nt_raddr),
    .rdata (nt_rdata)
  );

  // Decode of the request and the table read-backs
  logic              accept;
  logic              idx_ok, par_ok, tbl_par_ok;
  logic [AW-1:0]     n_eff;
  logic [NODE_W-1:0] tbl_par;
  logic [DUR_W-1:0]  tbl_dur;
  logic              out_free, can_emit, out_load;
  logic              w_last, retire, all_done;
  logic [3:0]        hit;
  logic [CHUNK_W-1:0] slice;
  logic              cand, any_n;
  logic [TIME_W-1:0] best_n;
  logic              emit_en;
  result_t           emit_res;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign idx_ok     = (node_index != '0) && (32'(node_index) <= 32'(MAX_NODES));
  assign par_ok     = (node_parent != '0) && (32'(node_parent) <= 32'(MAX_NODES));
  assign n_eff      = (32'(node_count) > 32'(MAX_NODES)) ? AW'(MAX_NODES) : AW'(node_count);
  assign tbl_par    = nt_rdata[NTW-1:DUR_W];
  assign tbl_dur    = nt_rdata[DUR_W-1:0];
  assign tbl_par_ok = (tbl_par != '0) && (32'(tbl_par) <= 32'(MAX_NODES));
  assign out_free   = !out_valid || out_ready;
  assign can_emit   = !held_valid || out_free;
  // load the output register from the holding register
  assign out_load   = (emit_en && held_valid) ||
                      ((state == S_FLUSH) && held_valid && out_free);
  assign w_last     = (w == WW'(NUM_WORKERS - 1));
  assign retire     = busy[w] && (wfin[w] == now);
  assign all_done   = (completed >= CW'(n_eff));
  assign slice      = ready[chunk * CHUNK_W +: CHUNK_W];
  assign hit        = lowest8(slice);
  // earliest busy finish, one worker a cycle
  assign cand       = busy[w] && (!any_r || (wfin[w] < best_r));
  assign any_n      = any_r || busy[w];
  assign best_n     = cand ? wfin[w] : best_r;

  always_comb begin
    pc_we    = 1'b0;
    pc_waddr = ptr;
    pc_wdata = '0;
    pc_re    = 1'b0;
    pc_raddr = ptr;
    nt_we    = 1'b0;
    nt_waddr = AW'(node_index);
    nt_wdata = {node_parent, node_duration};
    nt_re    = 1'b0;
    nt_raddr = t_r;
    emit_en  = 1'b0;
    emit_res = '{kind: EV_DONE, wid: '0, tsk: '0, evt: now, fin: '0};
    case (state)
      S_IDLE: begin
        if (accept && req_t'(req_type) == REQ_LOAD && idx_ok) begin
          nt_we    = 1'b1;
          pc_re    = par_ok;
          pc_raddr = AW'(node_parent);
        end
      end
      S_INIT: begin
        pc_we = 1'b1;
      end
      S_LOAD: begin
        pc_we    = 1'b1;
        pc_waddr = par_r;
        pc_wdata = (pc_rdata == CNT_SAT) ? pc_rdata : pc_rdata + 1'b1;
      end
      S_BEG_RD: begin
        pc_re = 1'b1;
      end
      S_RET_CHK: begin
        if (retire && can_emit) begin
          nt_re    = 1'b1;
          nt_raddr = wtask[w];
          emit_en  = 1'b1;
          emit_res = '{kind: EV_FINISH, wid: WID_W'(w), tsk: NODE_W'(wtask[w]),
                       evt: now, fin: '0};
        end
      end
      S_RET_TBL: begin
        pc_re    = tbl_par_ok;
        pc_raddr = AW'(tbl_par);
      end
      S_RET_CNT: begin
        pc_we    = (pc_rdata != '0);
        pc_waddr = par_r;
        pc_wdata = pc_rdata - 1'b1;
      end
      S_DSP_SCAN: begin
        nt_re    = hit[3];
        nt_raddr = AW'({chunk, hit[2:0]});
      end
      S_DSP_TBL: begin
        emit_en  = can_emit;
        emit_res = '{kind: EV_START, wid: WID_W'(w), tsk: NODE_W'(t_r),
                     evt: now, fin: now + TIME_W'(tbl_dur)};
      end
      S_RPT: begin
        emit_en = all_done && can_emit;
      end
      S_JUMP: begin
        if (w_last && !any_n) begin
          emit_en  = can_emit;
          emit_res = '{kind: EV_STALL, wid: '0, tsk: '0, evt: now, fin: '0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      node_count <= NODE_W'(1);
      ready      <= '0;
      now        <= '0;
      completed  <= '0;
      ptr        <= '0;
      w          <= '0;
      chunk      <= '0;
      any_r      <= 1'b0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        busy[i]  <= 1'b0;
        wtask[i] <= '0;
        wfin[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      // hold an unaccepted result, take a new one from the holding register
      out_valid <= out_load || (out_valid && !out_ready);
      // hand the held result on and hold the new one
      if (emit_en) begin
        if (held_valid) begin
          out_r     <= held;
          out_last  <= 1'b0;
        end
        held       <= emit_res;
        held_valid <= 1'b1;
      end

      case (state)
        S_INIT: begin
          ptr <= ptr + 1'b1;
          if (ptr == AW'(RW - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (req_t'(req_type))
              REQ_CLEAR: begin
                ready     <= '0;
                now       <= '0;
                completed <= '0;
                ptr       <= '0;
                for (int i = 0; i < NUM_WORKERS; i++) begin
                  busy[i]  <= 1'b0;
                  wtask[i] <= '0;
                  wfin[i]  <= '0;
                end
                state <= S_INIT;
              end
              REQ_LOAD: begin
                par_r <= AW'(node_parent);
                if (idx_ok && par_ok) begin
                  state <= S_LOAD;
                end
              end
              REQ_BEGIN: begin
                ptr <= AW'(1);
                if (n_eff != '0) begin
                  state <= S_BEG_RD;
                end
              end
              default: begin
                w     <= '0;
                state <= S_RET_CHK;
              end
            endcase
          end
        end
        S_LOAD: begin
          state <= S_IDLE;
        end
        S_BEG_RD: begin
          state <= S_BEG_CK;
        end
        S_BEG_CK: begin
          if (pc_rdata == '0) begin
            ready[ptr] <= 1'b1;
          end
          ptr <= ptr + 1'b1;
          state <= (ptr == n_eff) ? S_IDLE : S_BEG_RD;
        end
        S_RET_CHK: begin
          if (retire) begin
            if (can_emit) begin
              busy[w] <= 1'b0;
              if (completed != '1) begin
                completed <= completed + 1'b1;
              end
              state <= S_RET_TBL;
            end
          end else if (w_last) begin
            w     <= '0;
            state <= S_DSP_CHK;
          end else begin
            w <= w + 1'b1;
          end
        end
        S_RET_TBL: begin
          par_r <= AW'(tbl_par);
          if (tbl_par_ok) begin
            state <= S_RET_CNT;
          end else if (w_last) begin
            w     <= '0;
            state <= S_DSP_CHK;
          end else begin
            w     <= w + 1'b1;
            state <= S_RET_CHK;
          end
        end
        S_RET_CNT: begin
          // last child done: parent becomes ready
          if (pc_rdata == NODE_W'(1)) begin
            ready[par_r] <= 1'b1;
          end
          if (w_last) begin
            w     <= '0;
            state <= S_DSP_CHK;
          end else begin
            w     <= w + 1'b1;
            state <= S_RET_CHK;
          end
        end
        S_DSP_CHK: begin
          chunk <= '0;
          if (!busy[w]) begin
            state <= S_DSP_SCAN;
          end else if (w_last) begin
            state <= S_RPT;
          end else begin
            w <= w + 1'b1;
          end
        end
        S_DSP_SCAN: begin
          if (hit[3]) begin
            t_r                             <= AW'({chunk, hit[2:0]});
            ready[AW'({chunk, hit[2:0]})]   <= 1'b0;
            state                           <= S_DSP_TBL;
          end else if (chunk == CIW'(NCH - 1)) begin
            state <= S_RPT;
          end else begin
            chunk <= chunk + 1'b1;
          end
        end
        S_DSP_TBL: begin
          if (can_emit) begin
            busy[w]  <= 1'b1;
            wtask[w] <= t_r;
            wfin[w]  <= emit_res.fin;
            if (w_last) begin
              state <= S_RPT;
            end else begin
              w     <= w + 1'b1;
              state <= S_DSP_CHK;
            end
          end
        end
        S_RPT: begin
          w      <= '0;
          any_r  <= 1'b0;
          best_r <= '0;
          if (all_done) begin
            if (can_emit) begin
              state <= S_FLUSH;
            end
          end else begin
            state <= S_JUMP;
          end
        end
        S_JUMP: begin
          any_r  <= any_n;
          best_r <= best_n;
          if (!w_last) begin
            w <= w + 1'b1;
          end else if (any_n) begin
            now   <= best_n;
            state <= S_FLUSH;
          end else if (can_emit) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          // final result of the advance carries last
          if (!held_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_r      <= held;
            out_last   <= 1'b1;
            held_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign event_kind  = out_r.kind;
  assign worker      = out_r.wid;
  assign task_res    = out_r.tsk;
  assign event_time  = out_r.evt;
  assign finish_time = out_r.fin;
  assign last        = out_last;

  // nothing may be left held once a new request can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !held_valid)
    else $error("result held across requests");

  // a dispatched node has left the ready set
  a_taken: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSP_TBL) |-> !ready[t_r])
    else $error("dispatched node still ready");

  // count updates only ever target a real parent
  a_parent: assert property (@(posedge clk) disable iff (rst)
    (state == S_RET_CNT || state == S_LOAD) |-> (par_r != '0))
    else $error("count update on node zero");

  // a start is emitted only for a worker that is idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSP_TBL) |-> !busy[w])
    else $error("start on busy worker");

endmodule

### rtl/tpts_ram.sv
module tpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tpts_pkg::*;

  // One expected event, held at the block's own field widths.
  typedef struct {
    kind_t       kind;
    bit [1:0]    wid;
    bit [6:0]    tsk;
    bit [31:0]   evt;
    bit [31:0]   fin;
    bit          last;
  } sched_event_t;

  // Shadow of the scheduler: node tables, pending-child counts, ready set,
  // workers and time. It works out the events of every accepted request.
  class sched_scoreboard;
    bit [6:0]     node_cfg;
    bit [6:0]     parent_of [65];
    bit [15:0]    dur_of [65];
    bit [6:0]     kids_left [65];
    bit [64:0]    ready_mask;
    bit           busy [3];
    bit [6:0]     run_node [3];
    bit [31:0]    run_end [3];
    bit [31:0]    clock_now;
    int unsigned  retired;
    sched_event_t due_events [$];
    int           errors;
    bit           settled;

    function new();
      node_cfg = 7'd1;
      errors = 0;
      foreach (parent_of[i]) begin
        parent_of[i] = '0;
        dur_of[i] = '0;
      end
      clear_run();
    endfunction

    function void clear_run();
      foreach (kids_left[i]) kids_left[i] = '0;
      ready_mask = '0;
      for (int w = 0; w < 3; w++) begin
        busy[w] = 1'b0;
        run_node[w] = '0;
        run_end[w] = '0;
      end
      clock_now = '0;
      retired = 0;
    endfunction

    function void add_event(kind_t k, int w, bit [6:0] t, bit [31:0] f);
      sched_event_t e;
      e.kind = k;
      e.wid = 2'(w);
      e.tsk = t;
      e.evt = clock_now;
      e.fin = f;
      e.last = 1'b0;
      due_events.push_back(e);
    endfunction

    // Predict the events of one accepted request.
    function void note_request(req_t req, bit [6:0] idx, bit [6:0] par, bit [15:0] dur);
      int unsigned in_use;
      int unsigned first;
      int unsigned p;
      int          pick;
      bit          any_busy;
      bit [31:0]   soonest;
      in_use = (node_cfg > 64) ? 64 : node_cfg;
      first = due_events.size();
      settled = 1'b0;
      case (req)
        REQ_CLEAR: begin
          clear_run();
        end
        REQ_LOAD: begin
          if (idx != 0 && idx <= 64) begin
            parent_of[idx] = par;
            dur_of[idx] = dur;
            if (par != 0 && par <= 64 && kids_left[par] < 7'd127)
              kids_left[par]++;
          end
        end
        REQ_BEGIN: begin
          for (int i = 1; i <= in_use; i++)
            if (kids_left[i] == 0) ready_mask[i] = 1'b1;
        end
        default: begin
          // retire workers finishing now; the last child frees its parent
          for (int w = 0; w < 3; w++) begin
            if (busy[w] && run_end[w] == clock_now) begin
              busy[w] = 1'b0;
              retired++;
              add_event(EV_FINISH, w, run_node[w], '0);
              p = parent_of[run_node[w]];
              if (p != 0 && p <= 64 && kids_left[p] > 0) begin
                kids_left[p]--;
                if (kids_left[p] == 0) ready_mask[p] = 1'b1;
              end
            end
          end
          // hand the lowest ready node to each idle worker in turn
          for (int w = 0; w < 3; w++) begin
            if (!busy[w]) begin
              pick = 0;
              for (int i = 64; i >= 1; i--)
                if (ready_mask[i]) pick = i;
              if (pick == 0) break;
              ready_mask[pick] = 1'b0;
              busy[w] = 1'b1;
              run_node[w] = 7'(pick);
              run_end[w] = clock_now + dur_of[pick];
              add_event(EV_START, w, 7'(pick), run_end[w]);
            end
          end
          // report done or stall, else jump to the earliest finish
          if (retired >= in_use) begin
            add_event(EV_DONE, 0, '0, '0);
            settled = 1'b1;
          end else begin
            any_busy = 1'b0;
            soonest = '0;
            for (int w = 0; w < 3; w++) begin
              if (busy[w] && (!any_busy || run_end[w] < soonest)) begin
                soonest = run_end[w];
                any_busy = 1'b1;
              end
            end
            if (any_busy) begin
              clock_now = soonest;
            end else begin
              add_event(EV_STALL, 0, '0, '0);
              settled = 1'b1;
            end
          end
          if (due_events.size() > first)
            due_events[due_events.size() - 1].last = 1'b1;
        end
      endcase
    endfunction

    function void check_event(bit [1:0] kind, bit [1:0] wid, bit [6:0] tsk,
                              bit [31:0] evt, bit [31:0] fin, bit last);
      sched_event_t e;
      if (due_events.size() == 0) begin
        $display("%0t: unexpected event kind %0d task %0d", $time, kind, tsk);
        errors++;
        return;
      end
      e = due_events.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: event_kind exp %0d got %0d", $time, e.kind, kind);
        errors++;
      end
      if (wid !== e.wid) begin
        $display("%0t: worker exp %0d got %0d", $time, e.wid, wid);
        errors++;
      end
      if (tsk !== e.tsk) begin
        $display("%0t: task_res exp %0d got %0d", $time, e.tsk, tsk);
        errors++;
      end
      if (evt !== e.evt) begin
        $display("%0t: event_time exp %0d got %0d", $time, e.evt, evt);
        errors++;
      end
      if (fin !== e.fin) begin
        $display("%0t: finish_time exp %0d got %0d", $time, e.fin, fin);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last exp %0d got %0d", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [6:0]  node_index;
  logic [6:0]  node_parent;
  logic [15:0] node_duration;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  event_kind;
  logic [1:0]  worker;
  logic [6:0]  task_res;
  logic [31:0] event_time;
  logic [31:0] finish_time;
  logic        last;

  sched_scoreboard sb;
  int unsigned     sent;

  tree_precedence_task_scheduler uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .node_index(node_index),
    .node_parent(node_parent), .node_duration(node_duration),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_kind(event_kind), .worker(worker), .task_res(task_res),
    .event_time(event_time), .finish_time(finish_time), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one request, hold it until taken, then note it for prediction.
  // in_ready is sampled on the falling edge so the accept decision is free
  // of same-step races with the block's own flops.
  task automatic send_req(req_t req, bit [6:0] idx, bit [6:0] par, bit [15:0] dur);
    int  gap;
    bit  taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    node_index <= idx;
    node_parent <= par;
    node_duration <= dur;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    sb.note_request(req, idx, par, dur);
    sent++;
  endtask

  // Hold the input side until every predicted event has been seen, then let
  // the block finish any work that causes no event.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.due_events.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(bit [6:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.node_cfg = value;
  endtask

  // Advance until the run reports done or a stall, with a cap.
  task automatic run_to_end(int cap);
    for (int i = 0; i < cap; i++) begin
      send_req(REQ_ADVANCE, '0, '0, 16'($urandom));
      if (sb.settled) break;
    end
  endtask

  function automatic bit [15:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'd0;
    if (r < 90) return 16'($urandom_range(1, 20));
    return 16'($urandom);
  endfunction

  // One well-formed run: size, clear, tree load, begin, advance to the end.
  // Sprinkle ignored loads and stray parents in as noise, and now and then
  // skip the begin so the run stalls.
  task automatic random_run();
    int        n;
    bit [6:0]  par;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
    wait_idle();
    if (n == 64 && $urandom_range(0, 1))
      write_cfg(7'($urandom_range(65, 127)));
    else
      write_cfg(7'(n));
    send_req(REQ_CLEAR, 7'($urandom), 7'($urandom), 16'($urandom));
    for (int i = 1; i <= n; i++) begin
      if (i == n || $urandom_range(0, 9) == 0)
        par = '0;
      else
        par = 7'($urandom_range(i + 1, n));
      send_req(REQ_LOAD, 7'(i), par, pick_duration());
      if ($urandom_range(0, 9) == 0)
        send_req(REQ_LOAD, ($urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127))),
                 7'($urandom), 16'($urandom));
    end
    if ($urandom_range(0, 11) != 0) begin
      send_req(REQ_BEGIN, 7'($urandom), 7'($urandom), 16'($urandom));
      if ($urandom_range(0, 5) == 0)
        send_req(REQ_BEGIN, '0, '0, '0);
    end
    run_to_end(4 * n + 10);
    if ($urandom_range(0, 4) == 0)
      send_req(REQ_ADVANCE, '0, '0, '0);
  endtask

  // Result side: vary out_ready on the rising edge, take results on the
  // falling edge just before the edge that accepts them.
  initial begin : drain
    int  stall_left;
    bit  calm;
    stall_left = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) calm = ~calm;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
      end
      @(negedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_event(event_kind, worker, task_res, event_time, finish_time, last);
    end
  end

  initial begin : limit
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    bit [6:0] par;
    sb = new();
    sent = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    req_type = '0;
    node_index = '0;
    node_parent = '0;
    node_duration = '0;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Write every table entry once so no run ever reads an empty one.
    for (int i = 1; i <= 64; i++) begin
      par = (i == 64) ? 7'd0 : 7'($urandom_range(i + 1, 64));
      send_req(REQ_LOAD, 7'(i), par, 16'($urandom_range(0, 9)));
    end

    // Small tree with extreme durations, ignored loads, a bad parent and a
    // repeated begin; advance past done so done is reported again.
    wait_idle();
    write_cfg(7'd4);
    send_req(REQ_CLEAR, '0, '0, '0);
    send_req(REQ_LOAD, 7'd1, 7'd0, 16'd0);
    send_req(REQ_LOAD, 7'd2, 7'd1, 16'hFFFF);
    send_req(REQ_LOAD, 7'd3, 7'd1, 16'd1);
    send_req(REQ_LOAD, 7'd4, 7'd127, 16'd2);
    send_req(REQ_LOAD, 7'd0, 7'd64, 16'd5);
    send_req(REQ_LOAD, 7'd127, 7'd1, 16'd5);
    send_req(REQ_BEGIN, '0, '0, '0);
    send_req(REQ_BEGIN, '0, '0, '0);
    run_to_end(20);
    send_req(REQ_ADVANCE, '0, '0, '0);

    // Extra child finish: node 3 keeps a stale parent across the clear.
    send_req(REQ_LOAD, 7'd3, 7'd1, 16'd3);
    send_req(REQ_CLEAR, '0, '0, '0);
    send_req(REQ_LOAD, 7'd2, 7'd1, 16'd1);
    send_req(REQ_BEGIN, '0, '0, '0);
    run_to_end(20);

    // Cycle between two nodes: nothing is ever ready, so the run stalls.
    wait_idle();
    write_cfg(7'd2);
    send_req(REQ_CLEAR, '0, '0, '0);
    send_req(REQ_LOAD, 7'd1, 7'd2, 16'd4);
    send_req(REQ_LOAD, 7'd2, 7'd1, 16'd4);
    send_req(REQ_BEGIN, '0, '0, '0);
    send_req(REQ_ADVANCE, '0, '0, '0);

    // No nodes in use: done at once.
    wait_idle();
    write_cfg(7'd0);
    send_req(REQ_CLEAR, '0, '0, '0);
    send_req(REQ_ADVANCE, '0, '0, '0);

    // Saturate one pending count; the parent never frees and the run stalls.
    wait_idle();
    write_cfg(7'd2);
    send_req(REQ_CLEAR, '0, '0, '0);
    repeat (130) send_req(REQ_LOAD, 7'd2, 7'd1, 16'd3);
    send_req(REQ_BEGIN, '0, '0, '0);
    run_to_end(10);

    while (sent < 260) random_run();

    // Widest setting, whole tree in use.
    wait_idle();
    write_cfg(7'd127);
    send_req(REQ_CLEAR, '0, '0, '0);
    send_req(REQ_BEGIN, '0, '0, '0);
    run_to_end(300);

    wait_idle();
    if (sb.errors == 0 && sb.due_events.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
